@@ rtl/sqs_pkg.sv @@
// Shared types and constants for the sprite quad setup block.
`timescale 1ns / 1ps
`default_nettype none
package sqs_pkg;

  localparam int unsigned IdxPerQuad = 6;
  localparam int unsigned NumRegs    = 6;
  localparam int unsigned CntW       = 19;
  localparam int unsigned SlotW      = 7;
  localparam int unsigned CfgIdxW    = 3;

  typedef enum logic [2:0] {
    REG_R0_C01 = 3'd0,
    REG_R0_C23 = 3'd1,
    REG_R1_C01 = 3'd2,
    REG_R1_C23 = 3'd3,
    REG_R2_C01 = 3'd4,
    REG_R2_C23 = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_RD,
    F_CMP,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_FLUSH,
    B_MUL,
    B_SUM,
    B_OUT
  } back_state_t;

  // One classified request handed from front to back.
  typedef struct packed {
    logic               eob;
    logic               flush;
    logic [CntW-1:0]    flush_cnt;
    logic [SlotW-1:0]   slot;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] x1;
    logic signed [31:0] y1;
    logic [31:0]        rgba;
    logic [3:0][31:0]   uv;
  } cmd_t;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v > 33'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -33'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat51(input logic signed [50:0] v);
    logic signed [31:0] r;
    if (v > 51'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -51'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/sprite_quad_setup_with_texture_slots.sv @@
// Top level of the sprite quad setup block with texture slot assignment.
//
//  channel | direction | payload
//  in_     | slave     | tdata: sprite fields, tuser: req_type
//  out_    | master    | tdata: vertex fields, tuser: flags, tlast: last
//  cfg_    | slave     | cfg_index, cfg_data: matrix register write
//
// A request is taken in the idle state; the slot search then spends a read and a
// compare state per table entry examined because the slot table has one registered
// read port, appends a new id in the read state that finds none, and hands the word
// to the queue in the push state. The back end works each vertex in three rows,
// each a multiply state and a sum state, plus an output state; the idle state
// picks up the queue head, and a flush word takes a flush state.
// Reset clears the counters and restores the default matrix; a stalled output
// holds the back end, and the two-entry queue lets the slot search run ahead.
`timescale 1ns / 1ps
`default_nettype none
module sprite_quad_setup_with_texture_slots #(
  parameter int unsigned MAX_TEXTURES    = 32,
  parameter int unsigned MAX_BATCH_QUADS = 65536
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // pos_x, pos_y, pos_z, size_w, size_h, rgba, texture_id, uv_corner0..3
  input  wire logic [351:0] in_tdata,
  // req_type
  input  wire logic         in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // vert_x, vert_y, vert_z, vert_uv, slot_number, vert_rgba, batch_indices, zero pad
  output logic [191:0]      out_tdata,
  // batch_closed, vertex_valid
  output logic [1:0]        out_tuser,
  output logic              out_tlast,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [63:0]  cfg_data
);

  logic [5:0][63:0] mat_r;
  sqs_pkg::cmd_t    push_cmd, head;
  logic             push, q_full, pop, q_valid;

  assign cfg_ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r[sqs_pkg::REG_R0_C01] <= 64'h0000_0001_0000_0000;
      mat_r[sqs_pkg::REG_R0_C23] <= 64'd0;
      mat_r[sqs_pkg::REG_R1_C01] <= 64'h0000_0000_0001_0000;
      mat_r[sqs_pkg::REG_R1_C23] <= 64'd0;
      mat_r[sqs_pkg::REG_R2_C01] <= 64'd0;
      mat_r[sqs_pkg::REG_R2_C23] <= 64'h0000_0001_0000_0000;
    end else if (cfg_valid && cfg_ready &&
                 (cfg_index < sqs_pkg::CfgIdxW'(sqs_pkg::NumRegs))) begin
      mat_r[cfg_index] <= cfg_data;
    end
  end

  sqs_front #(
    .MAX_TEXTURES   (MAX_TEXTURES),
    .MAX_BATCH_QUADS(MAX_BATCH_QUADS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .push_cmd (push_cmd),
    .push     (push),
    .q_full   (q_full)
  );

  sqs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .head     (head),
    .not_empty(q_valid)
  );

  sqs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mat       (mat_r),
    .head      (head),
    .q_valid   (q_valid),
    .pop       (pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule
`default_nettype wire

@@ rtl/sqs_front.sv @@
// Front end: accepts requests, assigns texture slots, tracks the batch count.
`timescale 1ns / 1ps
`default_nettype none
module sqs_front #(
  parameter int unsigned MAX_TEXTURES    = 32,
  parameter int unsigned MAX_BATCH_QUADS = 65536
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [351:0]  in_tdata,
  input  wire logic          in_tuser,
  output sqs_pkg::cmd_t      push_cmd,
  output logic               push,
  input  wire logic          q_full
);

  localparam int unsigned TIW = (MAX_TEXTURES > 1) ? $clog2(MAX_TEXTURES) : 1;
  localparam int unsigned UW  = $clog2(MAX_TEXTURES + 1);
  localparam logic [sqs_pkg::CntW-1:0] CntLimit =
    sqs_pkg::CntW'(MAX_BATCH_QUADS * sqs_pkg::IdxPerQuad);

  sqs_pkg::front_state_t state_r, state_nxt;
  sqs_pkg::cmd_t         cmd_r;
  logic [31:0]           tid_r;
  logic [UW-1:0]         idx_r, used_r;
  logic [sqs_pkg::CntW-1:0] cnt_r;

  logic [31:0] table_mem [MAX_TEXTURES];
  logic [31:0] rd_data_r;
  logic        mem_we;
  logic [TIW-1:0] mem_waddr;

  logic        not_found, table_full;
  logic signed [31:0] in_px, in_py, in_w, in_h;

  assign in_px = in_tdata[31:0];
  assign in_py = in_tdata[63:32];
  assign in_w  = in_tdata[127:96];
  assign in_h  = in_tdata[159:128];

  assign not_found  = (state_r == sqs_pkg::F_RD) && (idx_r == used_r);
  assign table_full = (used_r == UW'(MAX_TEXTURES));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sqs_pkg::F_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser || (in_tdata[223:192] == 32'd0)) begin
            state_nxt = sqs_pkg::F_PUSH;
          end else begin
            state_nxt = sqs_pkg::F_RD;
          end
        end
      end
      sqs_pkg::F_RD:   state_nxt = not_found ? sqs_pkg::F_PUSH : sqs_pkg::F_CMP;
      sqs_pkg::F_CMP:  state_nxt = (rd_data_r == tid_r) ? sqs_pkg::F_PUSH : sqs_pkg::F_RD;
      sqs_pkg::F_PUSH: state_nxt = q_full ? sqs_pkg::F_PUSH : sqs_pkg::F_IDLE;
      default:         state_nxt = sqs_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    in_tready = (state_r == sqs_pkg::F_IDLE) && rst_n;
    push      = (state_r == sqs_pkg::F_PUSH) && !q_full;
    mem_we    = not_found;
    mem_waddr = table_full ? '0 : used_r[TIW-1:0];
  end

  assign push_cmd = cmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sqs_pkg::F_IDLE;
      used_r  <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_tvalid && in_tready) begin
        if (in_tuser || (cnt_r >= CntLimit)) begin
          used_r <= '0;
          cnt_r  <= '0;
        end
      end else if (not_found) begin
        if (table_full) begin
          used_r <= UW'(1);
          cnt_r  <= '0;
        end else begin
          used_r <= used_r + UW'(1);
        end
      end else if (push && !cmd_r.eob) begin
        cnt_r <= cnt_r + sqs_pkg::CntW'(sqs_pkg::IdxPerQuad);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r.eob       <= in_tuser;
      cmd_r.flush     <= in_tuser || (cnt_r >= CntLimit);
      cmd_r.flush_cnt <= cnt_r;
      cmd_r.slot      <= '0;
      cmd_r.px        <= in_px;
      cmd_r.py        <= in_py;
      cmd_r.pz        <= in_tdata[95:64];
      cmd_r.x1        <= sqs_pkg::sat33(33'(in_px) + 33'(in_w));
      cmd_r.y1        <= sqs_pkg::sat33(33'(in_py) + 33'(in_h));
      cmd_r.rgba      <= in_tdata[191:160];
      cmd_r.uv        <= in_tdata[351:224];
      tid_r           <= in_tdata[223:192];
      idx_r           <= '0;
    end else if (not_found) begin
      if (table_full) begin
        cmd_r.flush     <= 1'b1;
        cmd_r.flush_cnt <= cnt_r;
        cmd_r.slot      <= sqs_pkg::SlotW'(1);
      end else begin
        cmd_r.slot <= sqs_pkg::SlotW'(used_r) + sqs_pkg::SlotW'(1);
      end
    end else if (state_r == sqs_pkg::F_CMP) begin
      if (rd_data_r == tid_r) begin
        cmd_r.slot <= sqs_pkg::SlotW'(idx_r) + sqs_pkg::SlotW'(1);
      end else begin
        idx_r <= idx_r + UW'(1);
      end
    end
  end

  // Slot table: one write port, registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= tid_r;
    end
    rd_data_r <= table_mem[idx_r[TIW-1:0]];
  end

endmodule
`default_nettype wire

@@ rtl/sqs_queue.sv @@
// Two-entry command queue between front and back.
`timescale 1ns / 1ps
`default_nettype none
module sqs_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire sqs_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output sqs_pkg::cmd_t      head,
  output logic               not_empty
);

  sqs_pkg::cmd_t ent_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

@@ rtl/sqs_back.sv @@
// Back end: emits flush results and the four transformed corner vertices.
`timescale 1ns / 1ps
`default_nettype none
module sqs_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [5:0][63:0] mat,
  input  wire sqs_pkg::cmd_t    head,
  input  wire logic             q_valid,
  output logic                  pop,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [191:0]          out_tdata,
  output logic [1:0]            out_tuser,
  output logic                  out_tlast
);

  sqs_pkg::back_state_t state_r, state_nxt;
  logic [1:0]           corner_r, row_r;
  logic signed [63:0]   prod_r [3];
  logic signed [31:0]   vert_r [3];
  logic                 out_valid_r;
  logic [191:0]         out_data_r;
  logic [1:0]           out_user_r;
  logic                 out_last_r;

  logic                 slot_free, load_flush, load_vert;
  logic signed [31:0]   cx, cy, row_res;
  logic [63:0]          ma, mb;
  logic signed [65:0]   psum;
  logic signed [50:0]   shifted;

  assign slot_free = !out_valid_r || out_tready;
  assign cx = (corner_r == 2'd2 || corner_r == 2'd3) ? head.x1 : head.px;
  assign cy = (corner_r == 2'd1 || corner_r == 2'd2) ? head.y1 : head.py;
  assign ma = mat[{row_r, 1'b0}];
  assign mb = mat[{row_r, 1'b1}];

  // Floor of the Q32.32 sum back to Q16.16, then the translation term.
  assign psum    = 66'(prod_r[0]) + 66'(prod_r[1]) + 66'(prod_r[2]);
  assign shifted = 51'(psum >>> 16) + 51'($signed(mb[31:0]));
  assign row_res = sqs_pkg::sat51(shifted);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sqs_pkg::B_IDLE: begin
        if (q_valid) state_nxt = head.flush ? sqs_pkg::B_FLUSH : sqs_pkg::B_MUL;
      end
      sqs_pkg::B_FLUSH: begin
        if (slot_free) state_nxt = head.eob ? sqs_pkg::B_IDLE : sqs_pkg::B_MUL;
      end
      sqs_pkg::B_MUL: state_nxt = sqs_pkg::B_SUM;
      sqs_pkg::B_SUM: state_nxt = (row_r == 2'd2) ? sqs_pkg::B_OUT : sqs_pkg::B_MUL;
      sqs_pkg::B_OUT: begin
        if (slot_free) state_nxt = (corner_r == 2'd3) ? sqs_pkg::B_IDLE : sqs_pkg::B_MUL;
      end
      default: state_nxt = sqs_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    load_flush = (state_r == sqs_pkg::B_FLUSH) && slot_free;
    load_vert  = (state_r == sqs_pkg::B_OUT) && slot_free;
    pop        = (load_flush && head.eob) || (load_vert && corner_r == 2'd3);
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sqs_pkg::B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_flush || load_vert) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      sqs_pkg::B_IDLE: begin
        corner_r <= 2'd0;
        row_r    <= 2'd0;
      end
      sqs_pkg::B_MUL: begin
        prod_r[0] <= $signed(ma[63:32]) * cx;
        prod_r[1] <= $signed(ma[31:0]) * cy;
        prod_r[2] <= $signed(mb[63:32]) * head.pz;
      end
      sqs_pkg::B_SUM: begin
        vert_r[row_r] <= row_res;
        row_r         <= (row_r == 2'd2) ? 2'd0 : row_r + 2'd1;
      end
      sqs_pkg::B_OUT: begin
        if (slot_free) corner_r <= corner_r + 2'd1;
      end
      default: ;
    endcase
    if (load_flush) begin
      out_data_r <= {6'd0, head.flush_cnt, 167'd0};
      out_user_r <= 2'b01;
      out_last_r <= head.eob;
    end else if (load_vert) begin
      out_data_r <= {6'd0, {sqs_pkg::CntW{1'b0}}, head.rgba, head.slot,
                     head.uv[corner_r], vert_r[2], vert_r[1], vert_r[0]};
      out_user_r <= 2'b10;
      out_last_r <= (corner_r == 2'd3);
    end
  end

endmodule
`default_nettype wire
